// ----- hdl/mie_pkg.sv -----
// Shared types and constants for the modular inverse block.
// Used by the divider, datapath, controller, top level and checker.
`timescale 1ns / 1ps

package mie_pkg;

  localparam int WORD_BITS = 30;
  // Bezout coefficients stay within +/- modulus, two extra bits cover sign and headroom
  localparam int SBITS     = WORD_BITS + 2;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
  localparam int IN_BITS   = ((WORD_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = ((2 * WORD_BITS + 7) / 8) * 8;

  localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(998244353);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic mul;
    logic update;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic r_zero;
    logic div_done;
  } dp_status_t;

endpackage

// ----- hdl/mie_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on mie_pkg for the word width.
`timescale 1ns / 1ps

module mie_div
  import mie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic [WORD_BITS-1:0] quotient,
  output logic [WORD_BITS-1:0] remainder,
  output logic                 done
);

  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] dsr;
  logic [CNT_BITS-1:0]  cnt;
  logic                 busy;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   diff;
  logic                 fits;

  always_comb begin
    rem_sh = {rem, quo[WORD_BITS-1]};
    diff   = rem_sh - {1'b0, dsr};
    fits   = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when the divisor fits
      quo <= {quo[WORD_BITS-2:0], fits};
      rem <= fits ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- hdl/mie_dp.sv -----
// Datapath: remainder and coefficient registers, multiplier, final reduction.
// Depends on mie_pkg and instantiates mie_div.
`timescale 1ns / 1ps

module mie_dp
  import mie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WORD_BITS-1:0] modulus,
  input  logic [WORD_BITS-1:0] in_value,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [WORD_BITS-1:0] inverse,
  output logic [WORD_BITS-1:0] common_divisor
);

  logic [WORD_BITS-1:0]        r_prev;
  logic [WORD_BITS-1:0]        r_cur;
  logic signed [SBITS-1:0]     s_prev;
  logic signed [SBITS-1:0]     s_cur;
  logic signed [SBITS-1:0]     prod;
  logic [WORD_BITS-1:0]        quo;
  logic [WORD_BITS-1:0]        rem;
  logic                        div_done;
  logic signed [WORD_BITS+SBITS:0] prod_full;
  logic signed [SBITS-1:0]     m_s;
  logic signed [SBITS-1:0]     s_add;
  logic signed [SBITS-1:0]     s_sub;
  logic signed [SBITS-1:0]     s_red;

  mie_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (r_prev),
    .divisor   (r_cur),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  always_comb begin
    // only the low bits matter: the true product stays within the coefficient range
    prod_full = $signed({1'b0, quo}) * s_cur;
    m_s       = $signed({2'b00, modulus});
    s_add     = s_prev + m_s;
    s_sub     = s_prev - m_s;
    if (s_prev[SBITS-1]) begin
      s_red = s_add;
    end else if (s_prev >= m_s) begin
      s_red = s_sub;
    end else begin
      s_red = s_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_prev <= in_value;
      r_cur  <= modulus;
      s_prev <= SBITS'(1);
      s_cur  <= '0;
    end else if (cmd.update) begin
      r_prev <= r_cur;
      r_cur  <= rem;
      s_prev <= s_cur;
      s_cur  <= s_prev - prod;
    end
    if (cmd.mul) begin
      prod <= prod_full[SBITS-1:0];
    end
    if (cmd.out_load) begin
      inverse        <= (modulus == '0) ? '0 : s_red[WORD_BITS-1:0];
      common_divisor <= r_prev;
    end
  end

  assign status.r_zero   = (r_cur == '0);
  assign status.div_done = div_done;

endmodule

// ----- hdl/mie_ctrl.sv -----
// Controller: sequences load, divide, multiply and update steps, owns the handshakes.
// Depends on mie_pkg for the state and command types.
`timescale 1ns / 1ps

module mie_ctrl
  import mie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.r_zero) begin
          state_next = ST_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/modular_inverse_ext_euclid.sv -----
// Channel   Dir  Bits  Contents
// s_axis    in   32    value[29:0]
// m_axis    out  64    inverse[29:0], common_divisor[59:30]
// cfg       in   30    modulus, written on cfg_we
//
// Each Euclid step checks the remainder, runs the bit-serial divider, then multiplies and updates.
// Reset (rst, synchronous) loads the modulus with 998244353 and empties the output.
// The output register holds a finished result while the next item is taken in.
// Depends on mie_pkg, mie_ctrl, mie_dp.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid
  import mie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_BITS-1:0]   s_axis_tdata,   // value
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_BITS-1:0]  m_axis_tdata    // inverse, common_divisor
);

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] inverse;
  logic [WORD_BITS-1:0] common_divisor;
  dp_cmd_t              cmd;
  dp_status_t           status;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mie_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .modulus        (modulus),
    .in_value       (s_axis_tdata[WORD_BITS-1:0]),
    .cmd            (cmd),
    .status         (status),
    .inverse        (inverse),
    .common_divisor (common_divisor)
  );

  assign m_axis_tdata = OUT_BITS'({common_divisor, inverse});

endmodule

// ----- hdl/mie_checker.sv -----
// Port-level checker for the modular inverse block, bound to the top level.
// Depends on mie_pkg for the bus widths.
`timescale 1ns / 1ps

module mie_checker
  import mie_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_BITS-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in work");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_BITS-1:2*WORD_BITS] == '0)
    else $error("padding bits of result not zero");

endmodule

bind modular_inverse_ext_euclid mie_checker u_mie_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
